// ===== src/sbda_pkg.sv =====
package sbda_pkg;

  // Default width of the converted value.
  localparam int VALUE_BITS_DEF = 32;

  // Width of one packed decimal digit.
  localparam int DIGIT_W = 4;

  // Characters the block can produce.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Command word broadcast to every digit cell.
  typedef struct packed {
    logic clear;        // zero the digit
    logic shift_bit;    // one double-dabble step
    logic shift_digit;  // move digits one place toward the top cell
  } cell_ctrl_t;

endpackage

// ===== src/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII converter. Each input transaction carries
// one two's complement integer of VALUE_BITS bits; the block answers with its
// decimal text, one ASCII character per output transaction, most significant
// character first. A negative number starts with '-', leading zeros are
// dropped, a zero gives the single character '0', and the final character of
// each number has tlast set. The most negative value prints correctly (for 32
// bits, "-2147483648"). The magnitude is converted by a chain of BCD digit
// cells that shift in one bit per cycle. One number occupies the block for
// its accept, VALUE_BITS conversion steps, a sign if negative, and then
// one step per digit place (NUM_DIGITS places, ten at 32 bits). The next
// number is accepted as soon as the last character has been loaded into the
// output register, even while that character still waits to be taken.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // tdata fields, lowest bit up: value (VALUE_BITS, signed), zero padding.
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tdata fields, lowest bit up: ascii_char (8).
  output logic [7:0]                            m_tdata,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready
);

  // Decimal places needed for a VALUE_BITS magnitude (log10(2) ~ 0.30103).
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int DW         = sbda_pkg::DIGIT_W;

  sbda_pkg::state_t state, state_next;

  logic [VALUE_BITS-1:0] mag_sr;     // magnitude, shifted out msb first
  logic                  neg;        // number was negative
  logic                  started;    // first significant digit already sent
  logic [BIT_CNT_W-1:0]  bit_cnt;    // conversion steps left, minus one
  logic [DIG_CNT_W-1:0]  dig_cnt;    // digit places left to examine

  sbda_pkg::cell_ctrl_t  ctrl;
  logic [DW-1:0]         cell_digit [NUM_DIGITS];
  logic                  cell_carry [NUM_DIGITS];
  logic [DW-1:0]         top_digit;

  logic [VALUE_BITS-1:0] in_value;
  logic                  in_accept;
  logic                  out_load;   // output register free for a new character
  logic                  last_place;
  logic                  emit_digit; // this digit place produces a character
  logic                  send_sign;
  logic                  send_digit;

  assign in_value   = s_tdata[VALUE_BITS-1:0];
  assign in_accept  = s_tvalid && s_tready;
  assign out_load   = !m_tvalid || m_tready;
  assign top_digit  = cell_digit[NUM_DIGITS-1];
  assign last_place = (dig_cnt == DIG_CNT_W'(1));
  assign emit_digit = started || (top_digit != '0) || last_place;

  // The digit chain: cell 0 holds the ones place and receives the magnitude
  // bits; the top cell holds the most significant place and is the one read
  // out while digits are shifted up during emission.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic          carry_in;
    logic [DW-1:0] digit_in;
    if (i == 0) begin : g_first
      assign carry_in = mag_sr[VALUE_BITS-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign carry_in = cell_carry[i-1];
      assign digit_in = cell_digit[i-1];
    end
    sbda_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (carry_in),
      .digit_in  (digit_in),
      .carry_out (cell_carry[i]),
      .digit     (cell_digit[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbda_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sbda_pkg::ST_CONV;
        end
      end
      sbda_pkg::ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = neg ? sbda_pkg::ST_SIGN : sbda_pkg::ST_DIGITS;
        end
      end
      sbda_pkg::ST_SIGN: begin
        if (out_load) begin
          state_next = sbda_pkg::ST_DIGITS;
        end
      end
      sbda_pkg::ST_DIGITS: begin
        if (last_place && out_load) begin
          state_next = sbda_pkg::ST_IDLE;
        end
      end
      default: state_next = sbda_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready         = 1'b0;
    ctrl.clear       = 1'b0;
    ctrl.shift_bit   = 1'b0;
    ctrl.shift_digit = 1'b0;
    send_sign        = 1'b0;
    send_digit       = 1'b0;
    case (state)
      sbda_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        ctrl.clear = s_tvalid;
      end
      sbda_pkg::ST_CONV: begin
        ctrl.shift_bit = 1'b1;
      end
      sbda_pkg::ST_SIGN: begin
        send_sign = out_load;
      end
      sbda_pkg::ST_DIGITS: begin
        // Leading zeros are skipped without waiting on the output side.
        send_digit       = emit_digit && out_load;
        ctrl.shift_digit = !emit_digit || out_load;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbda_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (send_sign || send_digit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      neg     <= in_value[VALUE_BITS-1];
      // Negating the most negative value gives 2^(VALUE_BITS-1) read unsigned.
      mag_sr  <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bit_cnt <= BIT_CNT_W'(VALUE_BITS - 1);
      dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
      started <= 1'b0;
    end else begin
      if (ctrl.shift_bit) begin
        mag_sr  <= {mag_sr[VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      end
      if (ctrl.shift_digit) begin
        dig_cnt <= dig_cnt - DIG_CNT_W'(1);
      end
      if (send_digit) begin
        started <= 1'b1;
      end
    end
    if (send_sign) begin
      m_tdata <= sbda_pkg::CHAR_MINUS;
      m_tlast <= 1'b0;
    end else if (send_digit) begin
      m_tdata <= sbda_pkg::CHAR_ZERO + 8'(top_digit);
      m_tlast <= last_place;
    end
  end

  // No new number is taken while one is being converted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input accepted while a conversion is in progress");

  // A minus sign never ends a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == sbda_pkg::CHAR_MINUS) |-> !m_tlast)
    else $error("minus sign flagged as final character");

  // The cell chain must always hold valid decimal digits when read out.
  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    (state == sbda_pkg::ST_DIGITS) |-> (top_digit <= DW'(9)))
    else $error("digit cell holds a value above nine");

  // The last digit place always produces the final character.
  a_last_place: assert property (@(posedge clk) disable iff (rst)
    (state == sbda_pkg::ST_DIGITS) && last_place && out_load
    |=> (state == sbda_pkg::ST_IDLE) && m_tvalid && m_tlast)
    else $error("final digit place did not end the number");

endmodule

// ===== src/sbda_cell.sv =====
// One decimal digit of the conversion chain. During conversion it performs
// the add-3 correction and shifts one bit in from the cell below. During
// emission it takes the whole digit of the cell below.
module sbda_cell (
  input  logic                              clk,
  input  sbda_pkg::cell_ctrl_t              ctrl,
  input  logic                              carry_in,
  input  logic [sbda_pkg::DIGIT_W-1:0]      digit_in,
  output logic                              carry_out,
  output logic [sbda_pkg::DIGIT_W-1:0]      digit
);

  logic [sbda_pkg::DIGIT_W-1:0] adj;

  // A digit of five or more overflows past nine when doubled, so add three.
  assign adj       = (digit >= sbda_pkg::DIGIT_W'(5)) ? digit + sbda_pkg::DIGIT_W'(3) : digit;
  assign carry_out = adj[sbda_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift_bit) begin
      digit <= {adj[sbda_pkg::DIGIT_W-2:0], carry_in};
    end else if (ctrl.shift_digit) begin
      digit <= digit_in;
    end
  end

endmodule
